// File: src/wbs_pkg.sv
// ----------------------------------------------------------------------------
// Weighted block similarity: shared package
// Widths, constants and the structs passed between the front end, the queue,
// the back end and the shared divider.
// ----------------------------------------------------------------------------
package wbs_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int MAG_W       = 17;
    localparam int WIN_W       = 24;
    localparam int DIVISOR_W   = 25;
    localparam int WSUM_W      = 44;
    localparam int MSUM_W      = 28;
    localparam int PROD_W      = 34;
    localparam int SCORE_W     = 17;
    localparam int DIV_REM_W   = 28;
    localparam int DIV_Q_W     = 17;
    localparam int DIV_STEPS   = 17;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WIN_W-1:0]   DEFAULT_WINDOW = WIN_W'(328);
    localparam logic [SCORE_W-1:0] ONE_Q16        = SCORE_W'(65536);
    localparam logic [WSUM_W-1:0]  WSUM_MAX       = {WSUM_W{1'b1}};
    localparam logic [MSUM_W-1:0]  MSUM_MAX       = {MSUM_W{1'b1}};

    typedef struct packed {
        logic [MAG_W-1:0]     mag_b;
        logic [DIVISOR_W-1:0] divisor;
        logic [WIN_W-1:0]     win;
        logic                 last;
    } q_entry_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_REM_W-1:0] rem_init;
        logic [DIV_Q_W-1:0]   low_bits;
        logic [DIV_REM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_Q_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: src/wbs_if.sv
// ----------------------------------------------------------------------------
// Weighted block similarity: channel interfaces
// Ready/valid channels for sample pairs in and block scores out.
// ----------------------------------------------------------------------------
interface wbs_sample_if;
    logic                             valid;
    logic                             ready;
    logic signed [wbs_pkg::SAMPLE_W-1:0] sample_a;
    logic signed [wbs_pkg::SAMPLE_W-1:0] sample_b;
    logic                             last;

    modport source (output valid, output sample_a, output sample_b, output last,
                    input ready);
    modport sink (input valid, input sample_a, input sample_b, input last,
                  output ready);
endinterface

interface wbs_result_if;
    logic                           valid;
    logic                           ready;
    logic [wbs_pkg::SCORE_W-1:0]    score;
    logic                           valid_res;

    modport source (output valid, output score, output valid_res, input ready);
    modport sink (input valid, input score, input valid_res, output ready);
endinterface

// File: src/weighted_block_similarity_core.sv
// ----------------------------------------------------------------------------
// Weighted block similarity core
// Scores how closely a sample block follows a reference block, weighting each
// reference magnitude by how near the two magnitudes lie.
//
//   Channel   Kind          Payload
//   sample    ready/valid   sample_a[15:0] s, sample_b[15:0] s, last
//   result    ready/valid   score[16:0] (Q1.16), valid_res
//   cfg       write only    cfg_we, cfg_wdata[23:0] (window)
//
// In the back end each item's weight comes from the 17-step restoring
// divider; an item marked last also has its score divided there, unless
// the sums need no division.
// A two-entry queue and a front register take up to three items ahead of the
// back end, and a result register holds the score while the output stalls.
// Reset clears the window to zero (default 328) and both sums.
// ----------------------------------------------------------------------------
module weighted_block_similarity_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [wbs_pkg::WIN_W-1:0] cfg_wdata,
    wbs_sample_if.sink                sample,
    wbs_result_if.source              result
);
    import wbs_pkg::*;

    logic     push;
    q_entry_t push_entry;
    logic     q_ready;
    logic     pop;
    logic     q_valid;
    q_entry_t pop_entry;
    div_req_t div_req;
    div_rsp_t div_rsp;

    wbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .sample     (sample),
        .push       (push),
        .push_entry (push_entry),
        .q_ready    (q_ready)
    );

    wbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .q_ready    (q_ready),
        .pop        (pop),
        .q_valid    (q_valid),
        .pop_entry  (pop_entry)
    );

    wbs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    wbs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .pop_entry (pop_entry),
        .pop       (pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .result    (result)
    );

`ifndef SYNTHESIS
    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.score <= ONE_Q16))
        else $error("score above one");

    a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.valid_res) |-> (result.score == '0))
        else $error("invalid result with nonzero score");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_div_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> ($past(div_rsp.busy) && !div_rsp.busy))
        else $error("divider done without a run");
`endif

endmodule

// File: src/wbs_div.sv
// ----------------------------------------------------------------------------
// Weighted block similarity: shared divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wbs_div (
    input  logic              clk,
    input  logic              rst_n,
    input  wbs_pkg::div_req_t req,
    output wbs_pkg::div_rsp_t rsp
);
    import wbs_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_REM_W-1:0] rem_reg;
    logic [DIV_Q_W-1:0]   low_reg;
    logic [DIV_Q_W-1:0]   q_reg;
    logic [DIV_REM_W-1:0] divisor_reg;
    logic [DIV_REM_W:0]   trial;
    logic                 fits;

    assign trial = {rem_reg, low_reg[DIV_Q_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            low_reg <= {low_reg[DIV_Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[DIV_Q_W-2:0], fits};
            if (fits)
            begin
                rem_reg <= DIV_REM_W'(trial - {1'b0, divisor_reg});
            end
            else
            begin
                rem_reg <= trial[DIV_REM_W-1:0];
            end
        end
        else if (req.start)
        begin
            rem_reg     <= req.rem_init;
            low_reg     <= req.low_bits;
            divisor_reg <= req.divisor;
            q_reg       <= '0;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

// File: src/wbs_front.sv
// ----------------------------------------------------------------------------
// Weighted block similarity: front end
// Holds the window register, takes sample pairs, forms magnitudes, the
// magnitude difference and the weight divisor, and pushes mag_b, the divisor, the window and last to the queue.
// ----------------------------------------------------------------------------
module wbs_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [wbs_pkg::WIN_W-1:0] cfg_wdata,
    wbs_sample_if.sink               sample,
    output logic                     push,
    output wbs_pkg::q_entry_t        push_entry,
    input  logic                     q_ready
);
    import wbs_pkg::*;

    logic [WIN_W-1:0] window_reg;
    logic             fr_valid_reg;
    logic             fr_valid_next;
    q_entry_t         fr_entry_reg;
    q_entry_t         fr_entry_next;
    logic [WIN_W-1:0] win_eff;
    logic [MAG_W-1:0] mag_a;
    logic [MAG_W-1:0] mag_b;
    logic [MAG_W-1:0] diff;
    logic             take;

    function automatic logic [MAG_W-1:0] mag16(input logic [SAMPLE_W-1:0] v);
        logic [MAG_W-1:0] r;
        if (v[SAMPLE_W-1])
        begin
            r = MAG_W'(18'h10000 - {2'b00, v});
        end
        else
        begin
            r = {1'b0, v};
        end
        return r;
    endfunction

    assign win_eff = (window_reg == '0) ? DEFAULT_WINDOW : window_reg;
    assign mag_a   = mag16(sample.sample_a);
    assign mag_b   = mag16(sample.sample_b);
    assign diff    = (mag_a > mag_b) ? (mag_a - mag_b) : (mag_b - mag_a);

    assign sample.ready = !fr_valid_reg || q_ready;
    assign take         = sample.valid && sample.ready;
    assign push         = fr_valid_reg && q_ready;
    assign push_entry   = fr_entry_reg;

    always_comb
    begin
        fr_entry_next.mag_b   = mag_b;
        fr_entry_next.divisor = {{(DIVISOR_W - MAG_W){1'b0}}, diff} + {1'b0, win_eff};
        fr_entry_next.win     = win_eff;
        fr_entry_next.last    = sample.last;
        if (take)
        begin
            fr_valid_next = 1'b1;
        end
        else if (push)
        begin
            fr_valid_next = 1'b0;
        end
        else
        begin
            fr_valid_next = fr_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            fr_entry_reg <= fr_entry_next;
        end
    end

endmodule

// File: src/wbs_queue.sv
// ----------------------------------------------------------------------------
// Weighted block similarity: decoupling queue
// Two-entry FIFO of front-end entries between the front end and the back end.
// ----------------------------------------------------------------------------
module wbs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wbs_pkg::q_entry_t push_entry,
    output logic              q_ready,
    input  logic              pop,
    output logic              q_valid,
    output wbs_pkg::q_entry_t pop_entry
);
    import wbs_pkg::*;

    q_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign q_ready   = cnt_reg != QCNT_W'(QUEUE_DEPTH);
    assign q_valid   = cnt_reg != '0;
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: src/wbs_back.sv
// ----------------------------------------------------------------------------
// Weighted block similarity: back end
// Sequencer that computes each weight on the shared divider, accumulates the
// two sums, and at block end forms a score, dividing them where needed.
// ----------------------------------------------------------------------------
module wbs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  wbs_pkg::q_entry_t pop_entry,
    output logic              pop,
    output wbs_pkg::div_req_t div_req,
    input  wbs_pkg::div_rsp_t div_rsp,
    wbs_result_if.source      result
);
    import wbs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WDIV,
        ST_MUL,
        ST_ACC,
        ST_FIN,
        ST_SDIV,
        ST_OUT
    } state_t;

    state_t             state_reg;
    q_entry_t           cur_reg;
    logic [DIV_Q_W-1:0] weight_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [WSUM_W-1:0]  wsum_reg;
    logic [MSUM_W-1:0]  msum_reg;
    logic [SCORE_W-1:0] pend_score_reg;
    logic               pend_valid_reg;
    logic               out_valid_reg;
    logic [SCORE_W-1:0] out_score_reg;
    logic               out_vres_reg;
    div_req_t           div_req_reg;
    logic [WSUM_W:0]    wsum_add;
    logic [MSUM_W:0]    msum_add;
    logic [WSUM_W-1:0]  wsum_next;
    logic [MSUM_W-1:0]  msum_next;
    logic [SCORE_W-1:0] quot_clamped;

    assign pop = (state_reg == ST_IDLE) && q_valid;

    assign wsum_add  = {1'b0, wsum_reg} + {{(WSUM_W + 1 - PROD_W){1'b0}}, prod_reg};
    assign msum_add  = {1'b0, msum_reg} + {{(MSUM_W + 1 - MAG_W){1'b0}}, cur_reg.mag_b};
    assign wsum_next = wsum_add[WSUM_W] ? WSUM_MAX : wsum_add[WSUM_W-1:0];
    assign msum_next = msum_add[MSUM_W] ? MSUM_MAX : msum_add[MSUM_W-1:0];

    assign quot_clamped = (div_rsp.quotient > ONE_Q16) ? ONE_Q16 : div_rsp.quotient;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_reg        <= '0;
            weight_reg     <= '0;
            prod_reg       <= '0;
            pend_score_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_score_reg  <= '0;
            out_vres_reg   <= 1'b0;
            div_req_reg    <= '0;
            wsum_reg       <= '0;
            msum_reg       <= '0;
        end
        else
        begin
            div_req_reg.start <= 1'b0;
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg              <= pop_entry;
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.rem_init <= {{(DIV_REM_W - WIN_W + 1){1'b0}},
                                                 pop_entry.win[WIN_W-1:1]};
                        div_req_reg.low_bits <= {pop_entry.win[0], {(DIV_Q_W - 1){1'b0}}};
                        div_req_reg.divisor  <= {{(DIV_REM_W - DIVISOR_W){1'b0}},
                                                 pop_entry.divisor};
                        state_reg            <= ST_WDIV;
                    end
                end
                ST_WDIV:
                begin
                    if (div_rsp.done)
                    begin
                        weight_reg <= div_rsp.quotient;
                        state_reg  <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= PROD_W'(cur_reg.mag_b * weight_reg);
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    wsum_reg  <= wsum_next;
                    msum_reg  <= msum_next;
                    state_reg <= cur_reg.last ? ST_FIN : ST_IDLE;
                end
                ST_FIN:
                begin
                    if (msum_reg == '0)
                    begin
                        pend_score_reg <= '0;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_OUT;
                    end
                    else if ({1'b0, wsum_reg[WSUM_W-1:DIV_Q_W]} >= msum_reg)
                    begin
                        pend_score_reg <= ONE_Q16;
                        pend_valid_reg <= 1'b1;
                        state_reg      <= ST_OUT;
                    end
                    else
                    begin
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.rem_init <= {1'b0, wsum_reg[WSUM_W-1:DIV_Q_W]};
                        div_req_reg.low_bits <= wsum_reg[DIV_Q_W-1:0];
                        div_req_reg.divisor  <= msum_reg;
                        state_reg            <= ST_SDIV;
                    end
                end
                ST_SDIV:
                begin
                    if (div_rsp.done)
                    begin
                        pend_score_reg <= quot_clamped;
                        pend_valid_reg <= 1'b1;
                        state_reg      <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_score_reg <= pend_score_reg;
                        out_vres_reg  <= pend_valid_reg;
                        wsum_reg      <= '0;
                        msum_reg      <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign div_req          = div_req_reg;
    assign result.valid     = out_valid_reg;
    assign result.score     = out_score_reg;
    assign result.valid_res = out_vres_reg;

endmodule
